// ===== rtl/core/trilin_pkg.sv =====
// Shared constants and types for the trilinear refine interpolator.
// No dependencies; used by the core and by its port checker.
package trilin_pkg;

  // Subdivision factor per axis. It must be a power of two, because the
  // final divide by SCALE^3 is done as a shift.
  localparam int unsigned SCALE      = 4;
  localparam int unsigned VALUE_BITS = 16;
  localparam int unsigned AXIS_BITS  = 2;
  localparam int unsigned CORNERS    = 8;

  localparam int unsigned CUBE       = SCALE * SCALE * SCALE;
  localparam int unsigned CUBE_SHIFT = $clog2(CUBE);
  // axis weight 0..SCALE, corner weight 0..SCALE^3
  localparam int unsigned WBITS      = $clog2(SCALE + 1);
  localparam int unsigned PWBITS     = $clog2(CUBE + 1);
  localparam int unsigned PRODBITS   = VALUE_BITS + PWBITS;
  localparam int unsigned PAIRBITS   = PRODBITS + 1;
  localparam int unsigned SUMBITS    = PRODBITS + 3;

  typedef logic [VALUE_BITS-1:0] value_t;
  typedef logic [AXIS_BITS-1:0]  coord_t;
  typedef logic [WBITS-1:0]      axis_w_t;
  typedef logic [PWBITS-1:0]     corner_w_t;
  typedef logic [PRODBITS-1:0]   prod_t;
  typedef logic [PAIRBITS-1:0]   pair_t;
  typedef logic [SUMBITS-1:0]    sum_t;

endpackage

// ===== rtl/core/trilinear_refine_interpolator.sv =====
// Trilinear refine interpolator, five register stages.
// Throughput: one item per cycle while out_ready_i is high; each stage
// advances when the stage after it is empty or moving, so a stall only
// holds items in place.
// Reset: rst_ni clears all stage valid bits; data registers are not reset.
// Depends on trilin_pkg.
module trilinear_refine_interpolator (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [trilin_pkg::VALUE_BITS-1:0]  corner_000_i,
  input  logic [trilin_pkg::VALUE_BITS-1:0]  corner_001_i,
  input  logic [trilin_pkg::VALUE_BITS-1:0]  corner_010_i,
  input  logic [trilin_pkg::VALUE_BITS-1:0]  corner_011_i,
  input  logic [trilin_pkg::VALUE_BITS-1:0]  corner_100_i,
  input  logic [trilin_pkg::VALUE_BITS-1:0]  corner_101_i,
  input  logic [trilin_pkg::VALUE_BITS-1:0]  corner_110_i,
  input  logic [trilin_pkg::VALUE_BITS-1:0]  corner_111_i,
  input  logic [trilin_pkg::AXIS_BITS-1:0]   sub_x_i,
  input  logic [trilin_pkg::AXIS_BITS-1:0]   sub_y_i,
  input  logic [trilin_pkg::AXIS_BITS-1:0]   sub_z_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [trilin_pkg::VALUE_BITS-1:0]  interpolated_value_o
);

  localparam int unsigned NPAIR = trilin_pkg::CORNERS / 2;

  // stage valid bits and enables: s1 weights, s2 corner weights,
  // s3 products, s4 pair sums, s5 result register
  logic v1_q, v2_q, v3_q, v4_q, v5_q;
  logic en1, en2, en3, en4, en5;

  assign en5 = !v5_q || out_ready_i;
  assign en4 = !v4_q || en5;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign in_ready_o = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
      if (en5) v5_q <= v4_q;
    end
  end

  // ---------------- stage 1: clamp coordinates, axis weights
  trilin_pkg::value_t  corner_in [trilin_pkg::CORNERS];
  trilin_pkg::axis_w_t cx_d, cy_d, cz_d;

  assign corner_in[0] = corner_000_i;
  assign corner_in[1] = corner_001_i;
  assign corner_in[2] = corner_010_i;
  assign corner_in[3] = corner_011_i;
  assign corner_in[4] = corner_100_i;
  assign corner_in[5] = corner_101_i;
  assign corner_in[6] = corner_110_i;
  assign corner_in[7] = corner_111_i;

  function automatic trilin_pkg::axis_w_t clamp_coord(trilin_pkg::coord_t c);
    trilin_pkg::axis_w_t ce;
    ce = trilin_pkg::axis_w_t'(c);
    if (ce > trilin_pkg::axis_w_t'(trilin_pkg::SCALE - 1)) begin
      ce = trilin_pkg::axis_w_t'(trilin_pkg::SCALE - 1);
    end
    return ce;
  endfunction

  assign cx_d = clamp_coord(sub_x_i);
  assign cy_d = clamp_coord(sub_y_i);
  assign cz_d = clamp_coord(sub_z_i);

  trilin_pkg::value_t  corner1_q [trilin_pkg::CORNERS];
  trilin_pkg::axis_w_t wx_q [2];
  trilin_pkg::axis_w_t wy_q [2];
  trilin_pkg::axis_w_t wz_q [2];

  always_ff @(posedge clk_i) begin
    if (en1) begin
      corner1_q <= corner_in;
      wx_q[1]   <= cx_d;
      wx_q[0]   <= trilin_pkg::axis_w_t'(trilin_pkg::SCALE) - cx_d;
      wy_q[1]   <= cy_d;
      wy_q[0]   <= trilin_pkg::axis_w_t'(trilin_pkg::SCALE) - cy_d;
      wz_q[1]   <= cz_d;
      wz_q[0]   <= trilin_pkg::axis_w_t'(trilin_pkg::SCALE) - cz_d;
    end
  end

  // ---------------- stage 2: per-corner weights (small products)
  trilin_pkg::corner_w_t w_d [trilin_pkg::CORNERS];
  trilin_pkg::corner_w_t w_q [trilin_pkg::CORNERS];
  trilin_pkg::value_t    corner2_q [trilin_pkg::CORNERS];

  // corner n has x offset n[2], y offset n[1], z offset n[0]
  always_comb begin
    for (int n = 0; n < trilin_pkg::CORNERS; n++) begin
      w_d[n] = trilin_pkg::corner_w_t'(wx_q[(n >> 2) & 1])
             * trilin_pkg::corner_w_t'(wy_q[(n >> 1) & 1])
             * trilin_pkg::corner_w_t'(wz_q[n & 1]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en2) begin
      w_q       <= w_d;
      corner2_q <= corner1_q;
    end
  end

  // ---------------- stage 3: corner times weight
  trilin_pkg::prod_t prod_q [trilin_pkg::CORNERS];

  always_ff @(posedge clk_i) begin
    if (en3) begin
      for (int n = 0; n < trilin_pkg::CORNERS; n++) begin
        prod_q[n] <= trilin_pkg::prod_t'(corner2_q[n]) * trilin_pkg::prod_t'(w_q[n]);
      end
    end
  end

  // ---------------- stage 4: first level of the adder tree
  trilin_pkg::pair_t pair_q [NPAIR];

  always_ff @(posedge clk_i) begin
    if (en4) begin
      for (int p = 0; p < NPAIR; p++) begin
        pair_q[p] <= trilin_pkg::pair_t'(prod_q[2*p]) + trilin_pkg::pair_t'(prod_q[2*p+1]);
      end
    end
  end

  // ---------------- stage 5: final sum, round half up, divide by SCALE^3
  trilin_pkg::sum_t   acc_d;
  trilin_pkg::sum_t   rnd_d;
  trilin_pkg::value_t result_q;

  always_comb begin
    acc_d = '0;
    for (int p = 0; p < NPAIR; p++) begin
      acc_d = acc_d + trilin_pkg::sum_t'(pair_q[p]);
    end
    // the sum never exceeds max_value * SCALE^3, so the rounding add fits
    rnd_d = (acc_d + trilin_pkg::sum_t'(trilin_pkg::CUBE / 2)) >> trilin_pkg::CUBE_SHIFT;
  end

  always_ff @(posedge clk_i) begin
    if (en5) begin
      result_q <= rnd_d[trilin_pkg::VALUE_BITS-1:0];
    end
  end

  assign out_valid_o          = v5_q;
  assign interpolated_value_o = result_q;

endmodule

// ===== rtl/core/trilin_checker.sv =====
// Port-level checker for the trilinear refine interpolator, with its bind.
// Depends on trilin_pkg and the port list of trilinear_refine_interpolator.
module trilin_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_valid_i,
  input logic                               in_ready_o,
  input logic [trilin_pkg::VALUE_BITS-1:0]  corner_000_i,
  input logic [trilin_pkg::VALUE_BITS-1:0]  corner_001_i,
  input logic [trilin_pkg::VALUE_BITS-1:0]  corner_010_i,
  input logic [trilin_pkg::VALUE_BITS-1:0]  corner_011_i,
  input logic [trilin_pkg::VALUE_BITS-1:0]  corner_100_i,
  input logic [trilin_pkg::VALUE_BITS-1:0]  corner_101_i,
  input logic [trilin_pkg::VALUE_BITS-1:0]  corner_110_i,
  input logic [trilin_pkg::VALUE_BITS-1:0]  corner_111_i,
  input logic [trilin_pkg::AXIS_BITS-1:0]   sub_x_i,
  input logic [trilin_pkg::AXIS_BITS-1:0]   sub_y_i,
  input logic [trilin_pkg::AXIS_BITS-1:0]   sub_z_i,
  input logic                               out_valid_o,
  input logic                               out_ready_i,
  input logic [trilin_pkg::VALUE_BITS-1:0]  interpolated_value_o
);

  logic in_xfer;
  logic flat_cube;
  logic at_origin;

  assign in_xfer   = in_valid_i && in_ready_o;
  assign flat_cube = (corner_001_i == corner_000_i) && (corner_010_i == corner_000_i)
                  && (corner_011_i == corner_000_i) && (corner_100_i == corner_000_i)
                  && (corner_101_i == corner_000_i) && (corner_110_i == corner_000_i)
                  && (corner_111_i == corner_000_i);
  assign at_origin = (sub_x_i == '0) && (sub_y_i == '0) && (sub_z_i == '0);

  // result held until its transfer
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped before transfer");

  // async reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_o)
    else $error("result valid during reset");

  // equal corners interpolate to that value when the output does not stall
  a_flat_cube: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && flat_cube ##1 out_ready_i ##1 out_ready_i ##1 out_ready_i ##1 out_ready_i
    |-> ##1 (out_valid_o && interpolated_value_o == $past(corner_000_i, 5)))
    else $error("flat cube did not return its corner value");

  // origin point returns the origin corner
  a_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && at_origin ##1 out_ready_i ##1 out_ready_i ##1 out_ready_i ##1 out_ready_i
    |-> ##1 (out_valid_o && interpolated_value_o == $past(corner_000_i, 5)))
    else $error("origin point did not return corner_000");

endmodule

bind trilinear_refine_interpolator trilin_checker u_trilin_checker (.*);
